@@ rtl/tsms_pkg.sv @@
`default_nettype none
package tsms_pkg;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;

	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_DAC   = 2'd1;
	localparam logic [1:0] ACT_CONV  = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	localparam logic [1:0] CAUSE_DONE  = 2'd0;
	localparam logic [1:0] CAUSE_STOP  = 2'd1;
	localparam logic [1:0] CAUSE_BERR  = 2'd2;

	localparam logic [2:0] REG_MIN   = 3'd0;
	localparam logic [2:0] REG_MAX   = 3'd1;
	localparam logic [2:0] REG_STEP  = 3'd2;
	localparam logic [2:0] REG_FULL  = 3'd3;
	localparam logic [2:0] REG_SHUNT = 3'd4;

	localparam logic [1:0] PH_DAC  = 2'd0;
	localparam logic [1:0] PH_CONV = 2'd1;
	localparam logic [1:0] PH_READ = 2'd2;

	// divider width: numerators fit in 36 bits, 48 bits covers both uses
	localparam int DIV_W = 48;

	// controller to datapath
	typedef struct packed {
		logic load;      // latch a new input item
		logic div_dac;   // start divider on DAC numerator
		logic div_cur;   // start divider on current numerator
		logic finish;    // apply state update and build result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_dac;  // item is a DAC phase tick that needs division
		logic need_cur;  // item is a read tick that needs division
		logic div_done;
	} dp_sts_t;

	typedef struct packed {
		logic       busy_res;
		logic       start_rejected;
		logic [1:0] end_cause;
		logic       run_done;
		logic [8:0] point_index;
		logic       point_stored;
		logic signed [32:0] point_current_na;
		logic signed [15:0] point_raw;
		logic signed [14:0] point_voltage_mv;
		logic [15:0] dac_code;
		logic [1:0]  action;
	} result_t;

endpackage
`default_nettype wire

@@ rtl/tsms_div.sv @@
`default_nettype none
// Unsigned restoring divider, one quotient bit per cycle.
module tsms_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [tsms_pkg::DIV_W-1:0] num,
	input  wire logic [tsms_pkg::DIV_W-1:0] den,
	output logic done,
	output logic [tsms_pkg::DIV_W-1:0] quot
);
	import tsms_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] rem_q, quo_q, den_q;
	logic [CW-1:0]    cnt_q;
	logic             act_q;
	logic [DIV_W:0]   trial;

	assign trial = {rem_q, quo_q[DIV_W-1]} - {1'b0, den_q};

	// shift in one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				act_q <= 1'b1;
				cnt_q <= CW'(DIV_W);
			end else if (act_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					act_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (act_q) begin
			if (!trial[DIV_W]) begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign quot = quo_q;
endmodule
`default_nettype wire

@@ rtl/tsms_ctrl.sv @@
`default_nettype none
module tsms_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	input  wire tsms_pkg::dp_sts_t sts,
	output tsms_pkg::dp_cmd_t cmd
);
	import tsms_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DEC  = 5'b00010,
		ST_WAIT = 5'b00100,
		ST_FIN  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t st_q, st_d;

	assign s_tready = (st_q == ST_IDLE);
	assign m_tvalid = (st_q == ST_OUT);

	always_comb begin
		st_d = st_q;
		cmd  = '0;
		case (st_q)
			ST_IDLE: if (s_tvalid) begin
				cmd.load = 1'b1;
				st_d = ST_DEC;
			end
			ST_DEC: begin
				// start the divider if this item needs one
				if (sts.need_dac) begin
					cmd.div_dac = 1'b1;
					st_d = ST_WAIT;
				end else if (sts.need_cur) begin
					cmd.div_cur = 1'b1;
					st_d = ST_WAIT;
				end else st_d = ST_FIN;
			end
			ST_WAIT: if (sts.div_done) st_d = ST_FIN;
			ST_FIN: begin
				cmd.finish = 1'b1;
				st_d = ST_OUT;
			end
			ST_OUT: if (m_tready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end
endmodule
`default_nettype wire

@@ rtl/tsms_dp.sv @@
`default_nettype none
module tsms_dp #(
	parameter int MAX_POINTS = 400
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [19:0] cfg_data,
	input  wire logic [1:0]  in_opcode,
	input  wire logic [15:0] in_sample,
	input  wire logic        in_berr,
	input  wire tsms_pkg::dp_cmd_t cmd,
	output tsms_pkg::dp_sts_t sts,
	output tsms_pkg::result_t res
);
	import tsms_pkg::*;

	localparam int PW = $clog2(MAX_POINTS + 1);

	// configuration
	logic signed [14:0] min_q, max_q;
	logic [12:0] step_q;
	logic [15:0] full_q;
	logic [19:0] shunt_q;

	// sweep state
	logic               run_q, stop_q, down_q;
	logic [1:0]         ph_q;
	logic signed [15:0] volt_q;
	logic [PW-1:0]      pts_q;

	// latched item
	logic [1:0]  op_q;
	logic signed [15:0] raw_q;
	logic        berr_q;

	logic tick_live;
	assign tick_live = (op_q == OP_TICK) && run_q && !stop_q && !berr_q;

	logic v_le_min, v_ge_max;
	assign v_le_min = volt_q <= 16'(min_q);
	assign v_ge_max = volt_q >= 16'(max_q);

	assign sts.need_dac = tick_live && ph_q == PH_DAC && !v_le_min && !v_ge_max;
	assign sts.need_cur = tick_live && ph_q == PH_READ && shunt_q != '0;

	// divider operands
	logic [16:0] span, off;
	logic [33:0] prod;
	logic [DIV_W-1:0] num, den, quot;
	logic neg_q;
	logic [15:0] araw;
	logic [33:0] cur_mag;
	assign span = 17'(max_q) - 17'(min_q);
	assign off  = 17'(volt_q - 16'(min_q));
	assign araw = raw_q[15] ? 16'(-raw_q) : raw_q;
	assign cur_mag = 34'(araw) * 34'd125000;
	assign prod = 34'(off) * 34'(full_q);

	always_comb begin
		if (cmd.div_dac) begin
			num = DIV_W'({prod, 1'b0}) + DIV_W'(span);
			den = DIV_W'({span, 1'b0});
		end else begin
			num = DIV_W'(cur_mag);
			den = DIV_W'(shunt_q);
		end
	end

	tsms_div u_div (
		.clk(clk), .arst_n(arst_n),
		.start(cmd.div_dac | cmd.div_cur),
		.num(num), .den(den),
		.done(sts.div_done), .quot(quot)
	);

	// next voltage after a read
	logic signed [16:0] v_next;
	assign v_next = down_q ? 17'(volt_q) - 17'(step_q) : 17'(volt_q) + 17'(step_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_opcode;
			raw_q  <= in_sample;
			berr_q <= in_berr;
			neg_q  <= in_sample[15];
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= -15'sd4500;
			max_q   <= 15'sd4500;
			step_q  <= 13'd10;
			full_q  <= 16'd65535;
			shunt_q <= 20'd1000;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MIN:   min_q   <= cfg_data[14:0];
				REG_MAX:   max_q   <= cfg_data[14:0];
				REG_STEP:  step_q  <= cfg_data[12:0];
				REG_FULL:  full_q  <= cfg_data[15:0];
				REG_SHUNT: shunt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// apply the item and build the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			stop_q <= 1'b0;
			down_q <= 1'b0;
			ph_q   <= PH_DAC;
			volt_q <= '0;
			pts_q  <= '0;
			res    <= '0;
		end else if (cmd.finish) begin
			result_t r;
			r = '0;
			if (op_q == OP_START) begin
				if (run_q) r.start_rejected = 1'b1;
				else begin
					run_q  <= 1'b1;
					stop_q <= 1'b0;
					ph_q   <= PH_DAC;
					pts_q  <= '0;
					volt_q <= 16'(min_q);
					down_q <= 1'b0;
				end
			end else if (op_q == OP_STOP) begin
				if (run_q) stop_q <= 1'b1;
			end else if (op_q == OP_TICK && run_q) begin
				if (stop_q || berr_q) begin
					run_q <= 1'b0; stop_q <= 1'b0; ph_q <= PH_DAC;
					r.run_done = 1'b1;
					r.end_cause = stop_q ? CAUSE_STOP : CAUSE_BERR;
				end else if (ph_q == PH_DAC) begin
					r.action = ACT_DAC;
					r.dac_code = v_le_min ? '0 : v_ge_max ? full_q : quot[15:0];
					ph_q <= PH_CONV;
				end else if (ph_q == PH_CONV) begin
					r.action = ACT_CONV;
					ph_q <= PH_READ;
				end else if (ph_q == PH_READ) begin
					r.action = ACT_READ;
					r.point_voltage_mv = volt_q[14:0];
					r.point_raw = raw_q;
					if (shunt_q != '0)
						r.point_current_na = neg_q ? -33'(quot[32:0]) : 33'(quot[32:0]);
					if (32'(pts_q) < 32'(MAX_POINTS)) begin
						r.point_stored = 1'b1;
						r.point_index = 9'(pts_q);
						pts_q <= pts_q + 1'b1;
					end
					ph_q <= PH_DAC;
					if (v_next >= 17'(max_q)) begin
						volt_q <= 16'(max_q);
						down_q <= 1'b1;
					end else if (v_next <= 17'(min_q)) begin
						volt_q <= 16'(min_q);
						run_q <= 1'b0; stop_q <= 1'b0;
						r.run_done = 1'b1;
						r.end_cause = CAUSE_DONE;
					end else volt_q <= v_next[15:0];
				end else ph_q <= PH_DAC;
			end
			// busy follows the updated run flag
			if (op_q == OP_START) r.busy_res = 1'b1;
			else if (op_q == OP_TICK && run_q)
				r.busy_res = !(stop_q || berr_q ||
					(ph_q == PH_READ && !(v_next >= 17'(max_q)) && v_next <= 17'(min_q)));
			else r.busy_res = run_q;
			res <= r;
		end
	end
endmodule
`default_nettype wire

@@ rtl/triangle_sweep_measurement_sequencer_top.sv @@
`default_nettype none
// Channel   Dir  tdata (low bit up)
// s_axis    in   opcode[1:0], adc_sample[17:2], bus_error[18]
// m_axis    out  action, dac_code, point_voltage_mv, point_raw, point_current_na,
//                point_stored, point_index, run_done, end_cause, start_rejected, busy_res
// cfg       in   cfg_we, cfg_addr, cfg_data
// Each item passes through decode, an optional wait on the shared 48-step divider
// (DAC phase between ends, read phase with nonzero shunt), finish, then output until m_tready.
// One item in flight; s_tready is low until the result is taken.
// Reset (arst_n low) restores register defaults and an idle sweep.
module triangle_sweep_measurement_sequencer_top #(
	parameter int MAX_POINTS = 400
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [19:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // opcode, adc_sample, bus_error
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [103:0]     m_tdata   // result fields, action lowest, busy_res highest
);
	import tsms_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	result_t res;

	tsms_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.sts(sts), .cmd(cmd)
	);

	tsms_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.in_opcode(s_tdata[1:0]), .in_sample(s_tdata[17:2]), .in_berr(s_tdata[18]),
		.cmd(cmd), .sts(sts), .res(res)
	);

	assign m_tdata = {{(104 - $bits(result_t)){1'b0}}, res};
endmodule
`default_nettype wire
